// File: hw/rtl/brpt_pkg.sv
// blob reply parse and track: shared types, constants and helper functions
// used by the controller, datapath and divider; depends on nothing else

package brpt_pkg;

  localparam int POS_W = 7;
  localparam logic [POS_W-1:0] MAX_REPLY_LENGTH = 7'd99;
  localparam logic [7:0] NEWLINE = 8'h0A;
  localparam logic [7:0] NIB_MASK = 8'h0F;

  localparam int EDGE_W = 11;
  localparam int COUNT_W = 15;
  localparam int SERVO_W = 15;
  localparam int SMOOTH_W = 10;
  localparam int DAMP_W = 8;
  localparam int CFG_DATA_W = 15;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_CONFIDENCE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DAMPING = 1'd1;

  localparam logic [COUNT_W-1:0] CONF_RESET = 15'd0;
  localparam logic [DAMP_W-1:0] DAMP_RESET = 8'd4;
  localparam logic [SMOOTH_W-1:0] SMOOTH_X_RESET = 10'd40;
  localparam logic [SMOOTH_W-1:0] SMOOTH_Y_RESET = 10'd32;

  localparam logic [SERVO_W-1:0] OFF_X = 15'd40;
  localparam logic [SERVO_W-1:0] OFF_Y = 15'd254;
  localparam logic [SERVO_W-1:0] MUL_X = 15'd19;
  localparam logic [SERVO_W-1:0] MUL_Y = 15'd23;
  localparam logic [EDGE_W-1:0] LIMIT_X = 11'd81;
  localparam logic [EDGE_W-1:0] LIMIT_Y = 11'd65;

  localparam int DIV_W = 18;
  localparam int DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'(DIV_W - 1);

  typedef struct packed {
    logic take;
    logic decode;
    logic sum;
    logic div_start;
    logic div_sel_y;
    logic save_x;
    logic save_y;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic reply_end;
    logic gate;
    logic div_done;
  } status_t;

  // {kept, slot} for a reply position
  function automatic logic [4:0] slot_of(logic [POS_W-1:0] pos);
    logic [4:0] r;
    r = '0;
    if (pos >= 7'd6 && pos <= 7'd8) begin
      r = {1'b1, 4'(pos - 7'd6)};
    end else if (pos >= 7'd10 && pos <= 7'd12) begin
      r = {1'b1, 4'(pos - 7'd7)};
    end else if (pos >= 7'd14 && pos <= 7'd16) begin
      r = {1'b1, 4'(pos - 7'd8)};
    end else if (pos >= 7'd18 && pos <= 7'd20) begin
      r = {1'b1, 4'(pos - 7'd9)};
    end else if (pos >= 7'd25 && pos <= 7'd28) begin
      r = {1'b1, 4'(pos - 7'd13)};
    end
    return r;
  endfunction

  function automatic logic [EDGE_W-1:0] three_digits(logic [3:0] a, logic [3:0] b,
                                                     logic [3:0] c);
    return EDGE_W'(a) * 11'd100 + EDGE_W'(b) * 11'd10 + EDGE_W'(c);
  endfunction

  function automatic logic [COUNT_W-1:0] four_digits(logic [3:0] a, logic [3:0] b,
                                                     logic [3:0] c, logic [3:0] d);
    return COUNT_W'(a) * 15'd1000 + COUNT_W'(b) * 15'd100 + COUNT_W'(c) * 15'd10
         + COUNT_W'(d);
  endfunction

endpackage

// File: hw/rtl/blob_reply_parse_and_track_top.sv
// blob reply parse and track: top level joining controller and datapath
// depends on brpt_pkg, brpt_ctrl, brpt_datapath, brpt_div
//
//   channel  handshake              payload
//   in       in_valid / in_ready    rx_byte, new_reply
//   out      out_valid / out_ready  servo_*, track_valid, box_*, pixel_count, centroid_*
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a byte that does not end a reply is taken while the block stays idle; a
// reply-ending byte is followed by decode and sum and, when the gate passes,
// by the shared divider (18 quotient steps) run for x then y
// one transaction is worked on at a time; the result register frees the
// input side once loaded, and a stalled output holds the block before loading
// synchronous active-high reset clears digits and position and returns centre and config to their reset values

module blob_reply_parse_and_track_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         rx_byte,
  input  logic                               new_reply,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [brpt_pkg::SERVO_W-1:0]       servo_horizontal,
  output logic [brpt_pkg::SERVO_W-1:0]       servo_vertical,
  output logic                               track_valid,
  output logic [brpt_pkg::EDGE_W-1:0]        box_left,
  output logic [brpt_pkg::EDGE_W-1:0]        box_right,
  output logic [brpt_pkg::EDGE_W-1:0]        box_top,
  output logic [brpt_pkg::EDGE_W-1:0]        box_bottom,
  output logic [brpt_pkg::COUNT_W-1:0]       pixel_count,
  output logic [brpt_pkg::EDGE_W-1:0]        centroid_x,
  output logic [brpt_pkg::EDGE_W-1:0]        centroid_y,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [brpt_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [brpt_pkg::CFG_DATA_W-1:0]    cfg_data
);

  brpt_pkg::cmd_t     cmd;
  brpt_pkg::status_t  status;

  assign cfg_ready = 1'b1;

  brpt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  brpt_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .rx_byte          (rx_byte),
    .new_reply        (new_reply),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .servo_horizontal (servo_horizontal),
    .servo_vertical   (servo_vertical),
    .track_valid      (track_valid),
    .box_left         (box_left),
    .box_right        (box_right),
    .box_top          (box_top),
    .box_bottom       (box_bottom),
    .pixel_count      (pixel_count),
    .centroid_x       (centroid_x),
    .centroid_y       (centroid_y)
  );

endmodule

// File: hw/rtl/brpt_div.sv
// blob reply parse and track: restoring divider, one quotient bit per cycle
// depends on brpt_pkg

module brpt_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [brpt_pkg::DIV_W-1:0]       dividend,
  input  logic [brpt_pkg::DAMP_W-1:0]      divisor,
  output logic [brpt_pkg::DIV_W-1:0]       quotient,
  output logic                             done
);

  logic                              busy;
  logic [brpt_pkg::DIV_CNT_W-1:0]    cnt;
  logic [brpt_pkg::DAMP_W-1:0]       rem;
  logic [brpt_pkg::DAMP_W-1:0]       dsr;
  logic [brpt_pkg::DAMP_W:0]         rem_shift;
  logic                              fits;

  assign rem_shift = {rem, quotient[brpt_pkg::DIV_W-1]};
  assign fits = rem_shift >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == brpt_pkg::DIV_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= brpt_pkg::DAMP_W'(rem_shift - {1'b0, dsr});
      end else begin
        rem <= rem_shift[brpt_pkg::DAMP_W-1:0];
      end
      quotient <= {quotient[brpt_pkg::DIV_W-2:0], fits};
    end
  end

`ifndef NO_ASSERTIONS
  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
`endif

endmodule

// File: hw/rtl/brpt_datapath.sv
// blob reply parse and track: digit store, reply position, decode, gate,
// smoothing arithmetic and result registers; depends on brpt_pkg, brpt_div

module brpt_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  brpt_pkg::cmd_t                     cmd,
  output brpt_pkg::status_t                  status,
  input  logic [7:0]                         rx_byte,
  input  logic                               new_reply,
  input  logic                               cfg_we,
  input  logic [brpt_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [brpt_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic [brpt_pkg::SERVO_W-1:0]       servo_horizontal,
  output logic [brpt_pkg::SERVO_W-1:0]       servo_vertical,
  output logic                               track_valid,
  output logic [brpt_pkg::EDGE_W-1:0]        box_left,
  output logic [brpt_pkg::EDGE_W-1:0]        box_right,
  output logic [brpt_pkg::EDGE_W-1:0]        box_top,
  output logic [brpt_pkg::EDGE_W-1:0]        box_bottom,
  output logic [brpt_pkg::COUNT_W-1:0]       pixel_count,
  output logic [brpt_pkg::EDGE_W-1:0]        centroid_x,
  output logic [brpt_pkg::EDGE_W-1:0]        centroid_y
);

  logic [brpt_pkg::COUNT_W-1:0]   conf_thr;
  logic [brpt_pkg::DAMP_W-1:0]    damp_div;
  logic [3:0]                     digits [16];
  logic [brpt_pkg::POS_W-1:0]     pos;
  logic [brpt_pkg::SMOOTH_W-1:0]  smoothed_x;
  logic [brpt_pkg::SMOOTH_W-1:0]  smoothed_y;

  logic [brpt_pkg::POS_W-1:0]     pos_base;
  logic [brpt_pkg::POS_W-1:0]     pos_inc;
  logic [4:0]                     slot;

  logic [brpt_pkg::EDGE_W-1:0]    left, right, top, bottom;
  logic [brpt_pkg::COUNT_W-1:0]   count;
  logic [brpt_pkg::SERVO_W-1:0]   servo_h, servo_v;
  logic [brpt_pkg::EDGE_W-1:0]    cx, cy;
  logic                           gate;
  logic [brpt_pkg::DAMP_W-1:0]    d_eff;
  logic [brpt_pkg::DIV_W-1:0]     prod_x, prod_y;
  logic [brpt_pkg::SMOOTH_W-1:0]  qx, qy;

  logic [brpt_pkg::DAMP_W-1:0]    dm1;
  logic [brpt_pkg::EDGE_W:0]      sum_x, sum_y;
  logic [brpt_pkg::DIV_W-1:0]     dividend;
  logic [brpt_pkg::DIV_W-1:0]     quotient;
  logic                           div_done;

  assign pos_base = new_reply ? '0 : pos;
  assign pos_inc = pos_base + 1'b1;
  assign slot = brpt_pkg::slot_of(pos_base);

  assign status.reply_end = (pos_inc >= brpt_pkg::MAX_REPLY_LENGTH)
                         || (rx_byte == brpt_pkg::NEWLINE);
  assign status.gate = gate;
  assign status.div_done = div_done;

  assign dm1 = (damp_div == '0) ? '0 : damp_div - 1'b1;
  assign sum_x = {1'b0, left} + {1'b0, right};
  assign sum_y = {1'b0, top} + {1'b0, bottom};
  assign dividend = cmd.div_sel_y ? brpt_pkg::DIV_W'(cy) + prod_y
                                  : brpt_pkg::DIV_W'(cx) + prod_x;

  brpt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (d_eff),
    .quotient (quotient),
    .done     (div_done)
  );

  // configuration, reply position, digit store and smoothed centre
  always_ff @(posedge clk) begin
    if (rst) begin
      conf_thr <= brpt_pkg::CONF_RESET;
      damp_div <= brpt_pkg::DAMP_RESET;
      pos <= '0;
      smoothed_x <= brpt_pkg::SMOOTH_X_RESET;
      smoothed_y <= brpt_pkg::SMOOTH_Y_RESET;
      for (int i = 0; i < 16; i++) begin
        digits[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          brpt_pkg::CFG_CONFIDENCE: conf_thr <= cfg_data;
          brpt_pkg::CFG_DAMPING:    damp_div <= cfg_data[brpt_pkg::DAMP_W-1:0];
          default: ;
        endcase
      end
      if (cmd.take) begin
        if (slot[4]) begin
          digits[slot[3:0]] <= rx_byte[3:0] & brpt_pkg::NIB_MASK[3:0];
        end
        pos <= status.reply_end ? '0 : pos_inc;
      end
      if (cmd.load_out && gate) begin
        smoothed_x <= qx;
        smoothed_y <= qy;
      end
    end
  end

  // decode, arithmetic pipeline and result registers
  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      left <= brpt_pkg::three_digits(digits[0], digits[1], digits[2]);
      right <= brpt_pkg::three_digits(digits[3], digits[4], digits[5]);
      top <= brpt_pkg::three_digits(digits[6], digits[7], digits[8]);
      bottom <= brpt_pkg::three_digits(digits[9], digits[10], digits[11]);
      count <= brpt_pkg::four_digits(digits[12], digits[13], digits[14], digits[15]);
      servo_h <= brpt_pkg::OFF_X + brpt_pkg::SERVO_W'(smoothed_x) * brpt_pkg::MUL_X;
      servo_v <= brpt_pkg::OFF_Y + brpt_pkg::SERVO_W'(smoothed_y) * brpt_pkg::MUL_Y;
    end
    if (cmd.sum) begin
      cx <= sum_x[brpt_pkg::EDGE_W:1];
      cy <= sum_y[brpt_pkg::EDGE_W:1];
      gate <= (count > conf_thr) && (right < brpt_pkg::LIMIT_X)
           && (bottom < brpt_pkg::LIMIT_Y);
      d_eff <= (damp_div == '0) ? brpt_pkg::DAMP_W'(1) : damp_div;
      prod_x <= brpt_pkg::DIV_W'(smoothed_x) * brpt_pkg::DIV_W'(dm1);
      prod_y <= brpt_pkg::DIV_W'(smoothed_y) * brpt_pkg::DIV_W'(dm1);
    end
    if (cmd.save_x) begin
      qx <= quotient[brpt_pkg::SMOOTH_W-1:0];
    end
    if (cmd.save_y) begin
      qy <= quotient[brpt_pkg::SMOOTH_W-1:0];
    end
    if (cmd.load_out) begin
      servo_horizontal <= servo_h;
      servo_vertical <= servo_v;
      track_valid <= gate;
      box_left <= left;
      box_right <= right;
      box_top <= top;
      box_bottom <= bottom;
      pixel_count <= count;
      centroid_x <= cx;
      centroid_y <= cy;
    end
  end

`ifndef NO_ASSERTIONS
  a_quot_fits: assert property (@(posedge clk) disable iff (rst)
    (cmd.save_x || cmd.save_y) |-> (quotient[brpt_pkg::DIV_W-1:brpt_pkg::SMOOTH_W] == '0))
    else $error("smoothed centre overflows its width");
  a_centre_hold: assert property (@(posedge clk) disable iff (rst)
    (!rst && !(cmd.load_out && gate)) |=> ($stable(smoothed_x) && $stable(smoothed_y)))
    else $error("smoothed centre changed without a tracking update");
`endif

endmodule

// File: hw/rtl/brpt_ctrl.sv
// blob reply parse and track: controller state machine sequencing byte
// intake, decode, sum, the two divisions when the gate passes and result hand-off; depends on brpt_pkg

module brpt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output brpt_pkg::cmd_t     cmd,
  input  brpt_pkg::status_t  status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SUM,
    S_DIV_X_START,
    S_DIV_X,
    S_DIV_Y_START,
    S_DIV_Y,
    S_OUT
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.take = (state == S_IDLE) && in_valid;
    cmd.decode = (state == S_DECODE);
    cmd.sum = (state == S_SUM);
    cmd.div_start = ((state == S_DIV_X_START) && status.gate) || (state == S_DIV_Y_START);
    cmd.div_sel_y = (state == S_DIV_Y_START);
    cmd.save_x = (state == S_DIV_X) && status.div_done;
    cmd.save_y = (state == S_DIV_Y) && status.div_done;
    cmd.load_out = (state == S_OUT) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && status.reply_end) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: state <= S_SUM;
        S_SUM: state <= S_DIV_X_START;
        S_DIV_X_START: state <= status.gate ? S_DIV_X : S_OUT;
        S_DIV_X: begin
          if (status.div_done) begin
            state <= S_DIV_Y_START;
          end
        end
        S_DIV_Y_START: state <= S_DIV_Y;
        S_DIV_Y: begin
          if (status.div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (cmd.load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("result loaded but not presented");
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> (state == S_DIV_X || state == S_DIV_Y))
    else $error("divider finished outside a division state");
`endif

endmodule

// File: dv/brpt_checker.sv
// blob reply parse and track: checker that watches the input, config and result channels,
// predicts every finished reply and compares it with what the block returns
// depends on brpt_pkg for port widths and register indexes
`timescale 1ns / 100ps

module brpt_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [7:0]                         rx_byte,
  input  logic                               new_reply,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [brpt_pkg::SERVO_W-1:0]       servo_horizontal,
  input  logic [brpt_pkg::SERVO_W-1:0]       servo_vertical,
  input  logic                               track_valid,
  input  logic [brpt_pkg::EDGE_W-1:0]        box_left,
  input  logic [brpt_pkg::EDGE_W-1:0]        box_right,
  input  logic [brpt_pkg::EDGE_W-1:0]        box_top,
  input  logic [brpt_pkg::EDGE_W-1:0]        box_bottom,
  input  logic [brpt_pkg::COUNT_W-1:0]       pixel_count,
  input  logic [brpt_pkg::EDGE_W-1:0]        centroid_x,
  input  logic [brpt_pkg::EDGE_W-1:0]        centroid_y,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [brpt_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [brpt_pkg::CFG_DATA_W-1:0]    cfg_data,
  output int                                 mismatches,
  output int                                 awaiting,
  output int                                 reports,
  output int                                 tracked
);

  localparam int REPLY_MAX = 99;
  localparam logic [7:0] LINE_END = 8'h0A;

  typedef struct packed {
    logic [14:0] servo_h;
    logic [14:0] servo_v;
    logic        follow;
    logic [10:0] left;
    logic [10:0] right;
    logic [10:0] top;
    logic [10:0] bottom;
    logic [14:0] count;
    logic [10:0] cx;
    logic [10:0] cy;
  } blob_report_t;

  logic [3:0]   nibbles [16];
  logic [6:0]   position;
  logic [9:0]   centre_x;
  logic [9:0]   centre_y;
  logic [14:0]  threshold;
  logic [7:0]   divisor;
  blob_report_t reply_q [$];
  int           errs;
  int           seen;
  int           hits;

  always @(posedge clk) begin : watch
    blob_report_t want;
    blob_report_t got;
    int l, r, t, b, n, cx, cy, d;
    if (rst) begin
      foreach (nibbles[i]) nibbles[i] = 4'd0;
      position  = '0;
      centre_x  = 10'd40;
      centre_y  = 10'd32;
      threshold = '0;
      divisor   = 8'd4;
      reply_q.delete();
      errs = 0;
      seen = 0;
      hits = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {servo_horizontal, servo_vertical, track_valid, box_left, box_right, box_top,
               box_bottom, pixel_count, centroid_x, centroid_y};
        if (reply_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: result with nothing expected: sh=%0d sv=%0d trk=%0d", $realtime,
                     got.servo_h, got.servo_v, got.follow);
        end else begin
          want = reply_q.pop_front();
          seen++;
          if (want.follow) hits++;
          if (got !== want) begin
            errs++;
            if (errs <= 10) begin
              $display("%0t: exp sh=%0d sv=%0d trk=%0d l=%0d r=%0d t=%0d b=%0d n=%0d cx=%0d cy=%0d",
                       $realtime, want.servo_h, want.servo_v, want.follow, want.left,
                       want.right, want.top, want.bottom, want.count, want.cx, want.cy);
              $display("%0t: got sh=%0d sv=%0d trk=%0d l=%0d r=%0d t=%0d b=%0d n=%0d cx=%0d cy=%0d",
                       $realtime, got.servo_h, got.servo_v, got.follow, got.left,
                       got.right, got.top, got.bottom, got.count, got.cx, got.cy);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == brpt_pkg::CFG_CONFIDENCE) threshold = cfg_data;
        else if (cfg_index == brpt_pkg::CFG_DAMPING) divisor = cfg_data[7:0];
      end
      if (in_valid && in_ready) begin
        if (new_reply) position = '0;
        if (position inside {[6:8]}) nibbles[4'(position - 7'd6)] = rx_byte[3:0];
        else if (position inside {[10:12]}) nibbles[4'(position - 7'd7)] = rx_byte[3:0];
        else if (position inside {[14:16]}) nibbles[4'(position - 7'd8)] = rx_byte[3:0];
        else if (position inside {[18:20]}) nibbles[4'(position - 7'd9)] = rx_byte[3:0];
        else if (position inside {[25:28]}) nibbles[4'(position - 7'd13)] = rx_byte[3:0];
        position = position + 7'd1;
        if (position >= REPLY_MAX || rx_byte == LINE_END) begin
          position = '0;
          l  = nibbles[0] * 100 + nibbles[1] * 10 + nibbles[2];
          r  = nibbles[3] * 100 + nibbles[4] * 10 + nibbles[5];
          t  = nibbles[6] * 100 + nibbles[7] * 10 + nibbles[8];
          b  = nibbles[9] * 100 + nibbles[10] * 10 + nibbles[11];
          n  = nibbles[12] * 1000 + nibbles[13] * 100 + nibbles[14] * 10 + nibbles[15];
          cx = (l + r) >> 1;
          cy = (t + b) >> 1;
          want.servo_h = 15'(40 + 19 * centre_x);
          want.servo_v = 15'(254 + 23 * centre_y);
          want.follow  = (n > threshold) && (r < 81) && (b < 65);
          // centre moves toward the centroid only when the gate passes
          if (want.follow) begin
            d = (divisor == 8'd0) ? 1 : divisor;
            centre_x = 10'((cx + centre_x * (d - 1)) / d);
            centre_y = 10'((cy + centre_y * (d - 1)) / d);
          end
          want.left   = 11'(l);
          want.right  = 11'(r);
          want.top    = 11'(t);
          want.bottom = 11'(b);
          want.count  = 15'(n);
          want.cx     = 11'(cx);
          want.cy     = 11'(cy);
          reply_q.push_back(want);
        end
      end
    end
    mismatches <= errs;
    awaiting   <= reply_q.size();
    reports    <= seen;
    tracked    <= hits;
  end

endmodule

// File: dv/tb_top.sv
// blob reply parse and track: testbench top that resets the block, sends camera replies
// and register writes under changing back-pressure, and gives the verdict
// depends on brpt_pkg, blob_reply_parse_and_track_top and brpt_checker
`timescale 1ns / 100ps

module tb_top;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [7:0]                       rx_byte = '0;
  logic                             new_reply = 1'b0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [brpt_pkg::SERVO_W-1:0]     servo_horizontal;
  logic [brpt_pkg::SERVO_W-1:0]     servo_vertical;
  logic                             track_valid;
  logic [brpt_pkg::EDGE_W-1:0]      box_left;
  logic [brpt_pkg::EDGE_W-1:0]      box_right;
  logic [brpt_pkg::EDGE_W-1:0]      box_top;
  logic [brpt_pkg::EDGE_W-1:0]      box_bottom;
  logic [brpt_pkg::COUNT_W-1:0]     pixel_count;
  logic [brpt_pkg::EDGE_W-1:0]      centroid_x;
  logic [brpt_pkg::EDGE_W-1:0]      centroid_y;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [brpt_pkg::CFG_INDEX_W-1:0] cfg_index = brpt_pkg::CFG_CONFIDENCE;
  logic [brpt_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  int send_idle = 0;
  int recv_idle = 0;
  int bytes_sent = 0;
  int settings = 0;
  int mismatches, awaiting, reports, tracked;

  blob_reply_parse_and_track_top dut (.*);
  brpt_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  initial begin
    #5_000_000;
    $display("** blob_reply_parse_and_track_top: FAILED **");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic nr);
    if (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid  <= 1'b1;
    rx_byte   <= b;
    new_reply <= nr;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // digits go to the kept positions in order, filler elsewhere is never a newline
  task automatic send_reply(input logic [15:0][3:0] dig, input int len, input bit fresh,
                            input bit nl);
    int k;
    logic [7:0] b;
    k = 0;
    for (int p = 0; p < len; p++) begin
      if (p inside {[6:8], [10:12], [14:16], [18:20], [25:28]}) begin
        b = {($urandom_range(3) == 0) ? 4'($urandom_range(1, 15)) : 4'h3, dig[k]};
        k++;
      end else begin
        b = 8'($urandom);
        if (b == brpt_pkg::NEWLINE) b = 8'h20;
      end
      send_byte(b, fresh && p == 0);
    end
    if (nl) send_byte(brpt_pkg::NEWLINE, fresh && len == 0);
  endtask

  function automatic logic [15:0][3:0] pick_box(input bit inside_frame);
    logic [15:0][3:0] d;
    int v [5];
    v[0] = $urandom_range(999);
    v[1] = inside_frame ? $urandom_range(80) : $urandom_range(999);
    v[2] = $urandom_range(999);
    v[3] = inside_frame ? $urandom_range(64) : $urandom_range(999);
    v[4] = $urandom_range(9999);
    for (int i = 0; i < 4; i++) begin
      d[3*i]   = 4'(v[i] / 100);
      d[3*i+1] = 4'(v[i] / 10 % 10);
      d[3*i+2] = 4'(v[i] % 10);
    end
    d[12] = 4'(v[4] / 1000);
    d[13] = 4'(v[4] / 100 % 10);
    d[14] = 4'(v[4] / 10 % 10);
    d[15] = 4'(v[4] % 10);
    return d;
  endfunction

  task automatic write_regs(input logic [brpt_pkg::CFG_DATA_W-1:0] thr,
                            input logic [brpt_pkg::CFG_DATA_W-1:0] damp);
    cfg_valid <= 1'b1;
    cfg_index <= brpt_pkg::CFG_CONFIDENCE;
    cfg_data  <= thr;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= brpt_pkg::CFG_DAMPING;
    cfg_data  <= damp;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (64) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [15:0][3:0] dig;
    int pick;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    send_idle = 23;
    recv_idle = 67;

    // empty reply, all-max nibbles, gate edges at 80/64 and just outside, early newline
    send_byte(brpt_pkg::NEWLINE, 1'b1);
    send_reply(64'hFFFF_FFFF_FFFF_FFFF, 29, 1, 1);
    send_reply(64'h9999_4609_9908_0999, 29, 1, 1);
    send_reply(64'h9999_4609_9918_0999, 29, 1, 1);
    send_reply(64'h9999_5609_9908_0999, 29, 1, 1);
    send_reply(64'h0, 10, 1, 1);

    for (int seg = 0; seg < 9; seg++) begin
      settle();
      send_idle = (seg < 3) ? 23 : (seg < 6) ? 67 : 0;
      recv_idle = (seg < 3) ? 67 : (seg < 6) ? 23 : 0;
      case (seg)
        0: write_regs(15'd0, 15'd1);
        1: write_regs(15'd16665, 15'd255);
        2: write_regs(15'd0, 15'd0);
        default: write_regs(($urandom_range(3) == 0) ? 15'($urandom_range(16665))
                                                     : 15'($urandom_range(2000)),
                            {7'($urandom), 8'($urandom)});
      endcase
      while (bytes_sent < 130 + (seg + 1) * 180) begin
        pick = $urandom_range(99);
        dig = ($urandom_range(9) == 0) ? {$urandom, $urandom} : pick_box($urandom_range(9) < 7);
        if (pick < 60) begin
          send_reply(dig, $urandom_range(29, 34), $urandom_range(3) != 0, 1);
        end else if (pick < 70) begin
          if ($urandom_range(1) == 0) send_reply(dig, 99, 1, 0);
          else send_reply(dig, $urandom_range(35, 98), 1, 1);
        end else if (pick < 80) begin
          send_reply(dig, $urandom_range(0, 28), 1, 1);
        end else if (pick < 90) begin
          send_reply(dig, $urandom_range(1, 28), 1, 0);
          send_reply(pick_box(1), 29, 1, 1);
        end else begin
          repeat ($urandom_range(1, 8))
            send_byte(($urandom_range(3) == 0) ? brpt_pkg::NEWLINE : 8'($urandom),
                      $urandom_range(7) == 0);
        end
      end
    end
    settle();

    $display("sent %0d reply bytes over %0d register settings", bytes_sent, settings);
    $display("checked %0d finished replies, %0d of them passed the tracking gate",
             reports, tracked);
    if (mismatches == 0) begin
      $display("** blob_reply_parse_and_track_top: PASSED **");
    end else begin
      $display("** blob_reply_parse_and_track_top: FAILED **");
    end
    $finish;
  end

endmodule
